@@ rtl/core/uart_command_packet_framer_unit_defines.svh @@
// assertion macros shared by the framer modules
`ifndef UART_COMMAND_PACKET_FRAMER_UNIT_DEFINES_SVH
`define UART_COMMAND_PACKET_FRAMER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define UCPF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define UCPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ucpf_pkg.sv @@
// shared types and constants of the command packet framer
package ucpf_pkg;

    // request kinds
    localparam logic [1:0] UCPF_REQ_SHORT = 2'd0;
    localparam logic [1:0] UCPF_REQ_WRITE = 2'd1;
    localparam logic [1:0] UCPF_REQ_BATCH = 2'd2;
    localparam logic [1:0] UCPF_REQ_DATA  = 2'd3;

    // frame bytes
    localparam logic [7:0] UCPF_HDR0      = 8'h41;
    localparam logic [7:0] UCPF_HDR1      = 8'h44;
    localparam logic [7:0] UCPF_BATCH_CMD = 8'h43;
    localparam logic [7:0] UCPF_END       = 8'hFE;

    // job queue between the front and back ends
    localparam int UCPF_QDEPTH = 4;
    localparam int UCPF_PTR_W  = $clog2(UCPF_QDEPTH);
    localparam int UCPF_CNT_W  = $clog2(UCPF_QDEPTH + 1);

    // what the back end has to serialize for one request
    typedef enum logic [1:0] {
        KIND_FULL,   // 41 44 a b c FE sum
        KIND_BHDR,   // 41 44 43 a
        KIND_DATA,   // a
        KIND_LAST    // a FE sum
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic [7:0] sum;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ rtl/core/ucpf_if.sv @@
// handshake channels of the framer: request beats in, stream bytes out
interface ucpf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] cmd_byte;
    logic [7:0] arg_byte;
    logic [3:0] mode_bits;
    logic [7:0] fifth_byte;
    logic [7:0] triplet_count;

    modport source (
        output valid, req_type, cmd_byte, arg_byte, mode_bits, fifth_byte, triplet_count,
        input  ready
    );
    modport sink (
        input  valid, req_type, cmd_byte, arg_byte, mode_bits, fifth_byte, triplet_count,
        output ready
    );
endinterface

interface ucpf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (
        output valid, out_byte, frame_end,
        input  ready
    );
    modport sink (
        input  valid, out_byte, frame_end,
        output ready
    );
endinterface

@@ rtl/core/ucpf_queue.sv @@
// small register fifo of jobs between the front and back ends
`include "uart_command_packet_framer_unit_defines.svh"

module ucpf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ucpf_pkg::t_job       i_job,
    input  logic                 i_pop,
    output ucpf_pkg::t_job       o_job,
    output ucpf_pkg::t_q_status  o_status
);

    ucpf_pkg::t_job                      r_mem [ucpf_pkg::UCPF_QDEPTH];
    logic [ucpf_pkg::UCPF_PTR_W-1:0]     r_wr_ptr;
    logic [ucpf_pkg::UCPF_PTR_W-1:0]     r_rd_ptr;
    logic [ucpf_pkg::UCPF_CNT_W-1:0]     r_count;
    logic [ucpf_pkg::UCPF_CNT_W-1:0]     n_count;
    logic                                w_full;
    logic                                w_empty;
    logic                                w_wr;
    logic                                w_rd;

    assign w_full  = (r_count == ucpf_pkg::UCPF_CNT_W'(ucpf_pkg::UCPF_QDEPTH));
    assign w_empty = (r_count == '0);
    assign w_wr    = i_push && !w_full;
    assign w_rd    = i_pop && !w_empty;

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = w_full;
    assign o_status.empty = w_empty;

    `UCPF_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !w_full, "job pushed into full queue")
    `UCPF_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, !w_empty, "job popped from empty queue")

endmodule

@@ rtl/core/ucpf_front.sv @@
// front end: takes requests, tracks the open batch and queues byte jobs
`include "uart_command_packet_framer_unit_defines.svh"

module ucpf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ucpf_req_if.sink             i_req,
    input  ucpf_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output ucpf_pkg::t_job       o_job
);

    logic       r_open;
    logic [9:0] r_left;
    logic [7:0] r_sum;
    logic       n_open;
    logic [9:0] n_left;
    logic [7:0] n_sum;
    logic       w_accept;
    logic [7:0] w_mid;
    logic [7:0] w_full_sum;

    assign i_req.ready = !i_q_status.full;
    assign w_accept    = i_req.valid && i_req.ready;

    // fourth byte of a full frame
    assign w_mid = (i_req.req_type == ucpf_pkg::UCPF_REQ_SHORT)
                 ? (i_req.arg_byte | {4'h0, i_req.mode_bits}) : i_req.arg_byte;

    assign w_full_sum = 8'(ucpf_pkg::UCPF_HDR0 + ucpf_pkg::UCPF_HDR1 + ucpf_pkg::UCPF_END
                        + i_req.cmd_byte + w_mid + i_req.fifth_byte);

    always_comb begin
        n_open = r_open;
        n_left = r_left;
        n_sum  = r_sum;
        o_push = 1'b0;
        o_job  = '0;
        if (w_accept) begin
            case (i_req.req_type)
                ucpf_pkg::UCPF_REQ_DATA: begin
                    if (r_open) begin
                        o_push       = 1'b1;
                        o_job.byte_a = i_req.arg_byte;
                        if (r_left == 10'd1) begin
                            o_job.kind = ucpf_pkg::KIND_LAST;
                            o_job.sum  = 8'(r_sum + i_req.arg_byte + ucpf_pkg::UCPF_END);
                            n_open     = 1'b0;
                            n_left     = '0;
                            n_sum      = '0;
                        end else begin
                            o_job.kind = ucpf_pkg::KIND_DATA;
                            n_sum      = 8'(r_sum + i_req.arg_byte);
                            n_left     = r_left - 10'd1;
                        end
                    end
                end
                ucpf_pkg::UCPF_REQ_SHORT, ucpf_pkg::UCPF_REQ_WRITE: begin
                    if (!r_open) begin
                        o_push       = 1'b1;
                        o_job.kind   = ucpf_pkg::KIND_FULL;
                        o_job.byte_a = i_req.cmd_byte;
                        o_job.byte_b = w_mid;
                        o_job.byte_c = i_req.fifth_byte;
                        o_job.sum    = w_full_sum;
                    end
                end
                ucpf_pkg::UCPF_REQ_BATCH: begin
                    if (!r_open && (i_req.triplet_count != 8'd0)) begin
                        o_push       = 1'b1;
                        o_job.kind   = ucpf_pkg::KIND_BHDR;
                        o_job.byte_a = i_req.triplet_count;
                        n_open       = 1'b1;
                        // three data bytes per triplet
                        n_left       = {2'b00, i_req.triplet_count}
                                     + {1'b0, i_req.triplet_count, 1'b0};
                        n_sum        = 8'(ucpf_pkg::UCPF_HDR0 + ucpf_pkg::UCPF_HDR1
                                     + ucpf_pkg::UCPF_BATCH_CMD + i_req.triplet_count);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
            r_sum  <= '0;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
            r_sum  <= n_sum;
        end
    end

    `UCPF_ASSERT_IMPL(a_open_left, i_clk, i_rst_n, 1'b1, r_open == (r_left != 10'd0), "batch flag and byte count disagree")
    `UCPF_ASSERT_NEXT(a_hold_idle, i_clk, i_rst_n, !w_accept, $stable(r_sum) && $stable(r_left), "batch state moved without a request")

endmodule

@@ rtl/core/ucpf_back.sv @@
// back end: serializes queued jobs into the output byte stream
`include "uart_command_packet_framer_unit_defines.svh"

module ucpf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ucpf_pkg::t_job       i_job,
    input  ucpf_pkg::t_q_status  i_q_status,
    output logic                 o_pop,
    ucpf_byte_if.source          o_byte
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic [7:0] w_sel;
    logic       w_sel_end;
    logic [2:0] w_last_idx;
    logic       w_load;

    always_comb begin
        w_sel      = i_job.byte_a;
        w_sel_end  = 1'b0;
        w_last_idx = 3'd0;
        case (i_job.kind)
            ucpf_pkg::KIND_FULL: begin
                w_last_idx = 3'd6;
                case (r_idx)
                    3'd0:    w_sel = ucpf_pkg::UCPF_HDR0;
                    3'd1:    w_sel = ucpf_pkg::UCPF_HDR1;
                    3'd2:    w_sel = i_job.byte_a;
                    3'd3:    w_sel = i_job.byte_b;
                    3'd4:    w_sel = i_job.byte_c;
                    3'd5:    w_sel = ucpf_pkg::UCPF_END;
                    default: begin
                        w_sel     = i_job.sum;
                        w_sel_end = 1'b1;
                    end
                endcase
            end
            ucpf_pkg::KIND_BHDR: begin
                w_last_idx = 3'd3;
                case (r_idx)
                    3'd0:    w_sel = ucpf_pkg::UCPF_HDR0;
                    3'd1:    w_sel = ucpf_pkg::UCPF_HDR1;
                    3'd2:    w_sel = ucpf_pkg::UCPF_BATCH_CMD;
                    default: w_sel = i_job.byte_a;
                endcase
            end
            ucpf_pkg::KIND_LAST: begin
                w_last_idx = 3'd2;
                case (r_idx)
                    3'd0:    w_sel = i_job.byte_a;
                    3'd1:    w_sel = ucpf_pkg::UCPF_END;
                    default: begin
                        w_sel     = i_job.sum;
                        w_sel_end = 1'b1;
                    end
                endcase
            end
            default: begin
                w_sel      = i_job.byte_a;
                w_last_idx = 3'd0;
            end
        endcase
    end

    // output register refills whenever it is empty or being drained and the queue holds a job
    assign w_load = !i_q_status.empty && (!r_valid || o_byte.ready);
    assign o_pop  = w_load && (r_idx == w_last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= (r_idx == w_last_idx) ? 3'd0 : r_idx + 3'd1;
            end else if (o_byte.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_sel;
            r_end  <= w_sel_end;
        end
    end

    assign o_byte.valid     = r_valid;
    assign o_byte.out_byte  = r_byte;
    assign o_byte.frame_end = r_end;

    `UCPF_ASSERT_IMPL(a_end_closes_job, i_clk, i_rst_n, r_valid && r_end, r_idx == 3'd0, "frame end shown mid job")

endmodule

@@ rtl/core/uart_command_packet_framer_unit.sv @@
// Command packet framer: each request beat on i_req becomes zero to seven bytes on o_byte, one
// byte per cycle at most. A short command or register write yields a seven-byte frame, a batch
// header four, a batch data byte one, and the final data byte of a batch three (data, 0xFE,
// checksum with frame_end set). Requests that give no bytes (zero count, data outside a batch,
// other requests inside a batch) are still accepted. The front end classifies a request in the
// cycle it is taken and writes at most one job into a four-entry queue; i_req.ready drops only
// while that queue is full, so the sustained request rate is set by the one-byte-per-cycle
// output register of the back end while o_byte.ready is high. The first byte of a frame passes
// through the queue and then that output register; o_byte holds while o_byte.ready is low.
module uart_command_packet_framer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ucpf_req_if.sink     i_req,
    ucpf_byte_if.source  o_byte
);

    logic                 w_push;
    logic                 w_pop;
    ucpf_pkg::t_job       w_in_job;
    ucpf_pkg::t_job       w_head_job;
    ucpf_pkg::t_q_status  w_q_status;

    ucpf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_in_job)
    );

    ucpf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_in_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    ucpf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_head_job),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_byte     (o_byte)
    );

endmodule

@@ dv/ucpf_stream_checker.sv @@
// checker that predicts the framed byte stream from request beats and compares it
module ucpf_stream_checker
    import ucpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ucpf_req_if  i_req,
    ucpf_byte_if i_byte,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       frame_end;
    } t_stream_byte;

    t_stream_byte expected_bytes[$];
    logic         batch_open;
    logic [9:0]   bytes_left;
    logic [7:0]   batch_sum;
    int           fail_count;
    int           byte_index;

    function automatic void push_byte(input logic [7:0] b, input logic e);
        t_stream_byte sb;
        sb.stream_byte = b;
        sb.frame_end   = e;
        expected_bytes.push_back(sb);
    endfunction

    // complete frame: 41 44 b2 b3 b4 FE sum
    function automatic void push_full_frame(input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [7:0] b4);
        logic [7:0] sum;
        sum = UCPF_HDR0 + UCPF_HDR1 + b2 + b3 + b4 + UCPF_END;
        push_byte(UCPF_HDR0, 1'b0);
        push_byte(UCPF_HDR1, 1'b0);
        push_byte(b2, 1'b0);
        push_byte(b3, 1'b0);
        push_byte(b4, 1'b0);
        push_byte(UCPF_END, 1'b0);
        push_byte(sum, 1'b1);
    endfunction

    function automatic void predict_frame_bytes(
        input logic [1:0] kind,
        input logic [7:0] cmd,
        input logic [7:0] arg,
        input logic [3:0] mode,
        input logic [7:0] fifth,
        input logic [7:0] count
    );
        if (kind == UCPF_REQ_DATA) begin
            if (batch_open) begin
                push_byte(arg, 1'b0);
                batch_sum  = batch_sum + arg;
                bytes_left = bytes_left - 10'd1;
                if (bytes_left == 10'd0) begin
                    push_byte(UCPF_END, 1'b0);
                    batch_sum = batch_sum + UCPF_END;
                    push_byte(batch_sum, 1'b1);
                    batch_open = 1'b0;
                    batch_sum  = 8'h00;
                end
            end
        end else if (!batch_open) begin
            case (kind)
                UCPF_REQ_SHORT: push_full_frame(cmd, arg | {4'h0, mode}, fifth);
                UCPF_REQ_WRITE: push_full_frame(cmd, arg, fifth);
                default: begin
                    if (count != 8'h00) begin
                        push_byte(UCPF_HDR0, 1'b0);
                        push_byte(UCPF_HDR1, 1'b0);
                        push_byte(UCPF_BATCH_CMD, 1'b0);
                        push_byte(count, 1'b0);
                        batch_sum  = UCPF_HDR0 + UCPF_HDR1 + UCPF_BATCH_CMD + count;
                        bytes_left = 10'(count) * 10'd3;
                        batch_open = 1'b1;
                    end
                end
            endcase
        end
    endfunction

    function automatic void check_stream_byte(input logic [7:0] b, input logic e);
        t_stream_byte want;
        if (expected_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("[%0t] byte beat %0d: got %h end %b with nothing predicted",
                         $time, byte_index, b, e);
        end else begin
            want = expected_bytes.pop_front();
            if (want.stream_byte !== b || want.frame_end !== e) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] byte beat %0d: expected %h end %b, got %h end %b",
                             $time, byte_index, want.stream_byte, want.frame_end, b, e);
            end
        end
        byte_index++;
    endfunction

    initial begin
        fail_count   = 0;
        byte_index   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        batch_open   = 1'b0;
        bytes_left   = 10'd0;
        batch_sum    = 8'h00;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bytes.delete();
            batch_open = 1'b0;
            bytes_left = 10'd0;
            batch_sum  = 8'h00;
        end else begin
            if (i_req.valid && i_req.ready)
                predict_frame_bytes(i_req.req_type, i_req.cmd_byte, i_req.arg_byte,
                                    i_req.mode_bits, i_req.fifth_byte, i_req.triplet_count);
            if (i_byte.valid && i_byte.ready)
                check_stream_byte(i_byte.out_byte, i_byte.frame_end);
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= fail_count;
    end

endmodule

@@ dv/tb_uart_command_packet_framer_unit.sv @@
// top of the framer testbench: clock, reset, request stimulus, output stalls and verdict
module tb_uart_command_packet_framer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ucpf_pkg::*;

    localparam int HOLD_OFF_CYCLES = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ucpf_req_if  req_ch();
    ucpf_byte_if byte_ch();

    int fail_count;
    int pending_bytes;

    // stimulus-side view of the batch, used only to steer the random mix and to close the final batch
    int data_left;
    int useful_items;

    int send_idle_pct;
    int stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;

    uart_command_packet_framer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_byte  (byte_ch)
    );

    ucpf_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_byte       (byte_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_bytes)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // output side: random stalls plus a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            byte_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            byte_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_request(
        input logic [1:0] kind,
        input logic [7:0] cmd,
        input logic [7:0] arg,
        input logic [3:0] mode,
        input logic [7:0] fifth,
        input logic [7:0] count
    );
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.cmd_byte      <= cmd;
        req_ch.arg_byte      <= arg;
        req_ch.mode_bits     <= mode;
        req_ch.fifth_byte    <= fifth;
        req_ch.triplet_count <= count;
        do @(posedge i_clk); while (!req_ch.ready);
        if (kind == UCPF_REQ_DATA) begin
            if (data_left > 0) begin
                data_left--;
                useful_items++;
            end
        end else if (data_left == 0) begin
            if (kind != UCPF_REQ_BATCH || count != 8'h00)
                useful_items++;
            if (kind == UCPF_REQ_BATCH && count != 8'h00)
                data_left = 3 * count;
        end
    endtask

    task automatic send_random(input logic [1:0] kind, input logic [7:0] count);
        send_request(kind, 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom), count);
    endtask

    task automatic random_phase(input int idle_pct, input int stall, input int n_items);
        int target;
        int pick;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        target        = useful_items + n_items;
        while (useful_items < target || data_left > 0) begin
            pick = $urandom_range(99);
            if (data_left > 0) begin
                if (pick < 90)
                    send_random(UCPF_REQ_DATA, 8'($urandom));
                else
                    send_random(2'($urandom_range(2)), 8'($urandom));
            end else if (pick < 30) begin
                send_random(UCPF_REQ_SHORT, 8'($urandom));
            end else if (pick < 55) begin
                send_random(UCPF_REQ_WRITE, 8'($urandom));
            end else if (pick < 80) begin
                send_random(UCPF_REQ_BATCH, 8'($urandom_range(4, 1)));
            end else if (pick < 83) begin
                send_random(UCPF_REQ_BATCH, 8'($urandom_range(12, 5)));
            end else if (pick < 90) begin
                send_random(UCPF_REQ_BATCH, 8'h00);
            end else begin
                send_random(UCPF_REQ_DATA, 8'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = UCPF_REQ_SHORT;
        req_ch.cmd_byte      = 8'h00;
        req_ch.arg_byte      = 8'h00;
        req_ch.mode_bits     = 4'h0;
        req_ch.fifth_byte    = 8'h00;
        req_ch.triplet_count = 8'h00;
        byte_ch.ready        = 1'b0;
        data_left            = 0;
        useful_items         = 0;
        send_idle_pct        = 0;
        stall_pct            = 0;
        hold_requests        = 0;
        hold_served          = 0;
        hold_left            = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every request kind, the ignored cases, batch close
        send_request(UCPF_REQ_SHORT, 8'h00, 8'h00, 4'h0, 8'h00, 8'h00);
        send_request(UCPF_REQ_SHORT, 8'hFF, 8'hFF, 4'hF, 8'hFF, 8'hFF);
        send_request(UCPF_REQ_SHORT, 8'h5A, 8'hA0, 4'h5, 8'h3C, 8'h81);
        send_request(UCPF_REQ_WRITE, 8'h00, 8'h00, 4'hF, 8'h00, 8'h00);
        send_request(UCPF_REQ_WRITE, 8'hFF, 8'hFF, 4'h0, 8'hFF, 8'hFF);
        send_request(UCPF_REQ_BATCH, 8'h12, 8'h34, 4'h6, 8'h78, 8'h00);
        send_request(UCPF_REQ_DATA,  8'h00, 8'hAA, 4'h0, 8'h00, 8'h00);
        send_request(UCPF_REQ_BATCH, 8'h00, 8'h00, 4'h0, 8'h00, 8'h01);
        send_request(UCPF_REQ_SHORT, 8'h11, 8'h22, 4'h3, 8'h44, 8'h00);
        send_request(UCPF_REQ_WRITE, 8'h55, 8'h66, 4'h0, 8'h77, 8'h00);
        send_request(UCPF_REQ_BATCH, 8'h00, 8'h00, 4'h0, 8'h00, 8'h02);
        send_request(UCPF_REQ_DATA,  8'h00, 8'hFF, 4'h0, 8'h00, 8'h00);
        send_request(UCPF_REQ_DATA,  8'h00, 8'h00, 4'h0, 8'h00, 8'h00);
        send_request(UCPF_REQ_DATA,  8'h00, 8'h7F, 4'h0, 8'h00, 8'h00);
        send_request(UCPF_REQ_DATA,  8'h00, 8'h01, 4'h0, 8'h00, 8'h00);
        send_request(UCPF_REQ_BATCH, 8'hFF, 8'hFF, 4'hF, 8'hFF, 8'h02);
        repeat (6) send_request(UCPF_REQ_DATA, 8'hFF, 8'hFF, 4'hF, 8'hFF, 8'hFF);

        // output held off while full frames keep coming, so the input side backs up
        hold_requests++;
        repeat (12) send_random(UCPF_REQ_SHORT, 8'($urandom));

        random_phase(0, 0, 30);
        random_phase(54, 0, 30);
        random_phase(0, 54, 30);
        random_phase(10, 10, 30);

        // one longer batch to finish
        send_random(UCPF_REQ_BATCH, 8'h10);
        while (data_left > 0) send_random(UCPF_REQ_DATA, 8'($urandom));

        req_ch.valid <= 1'b0;
        stall_pct = 0;
        do @(posedge i_clk); while (pending_bytes != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
